[rtl/msps_pkg.sv]
`timescale 1ns / 1ps
// shared types, widths and codes for the markov state path sampler
package msps_pkg;

    localparam int MAX_STATES = 16;
    localparam int PROB_BITS  = 16;

    localparam int IDX_W     = $clog2(MAX_STATES);
    localparam int CNT_W     = $clog2(MAX_STATES + 1);
    localparam int PROB_W    = PROB_BITS + 1;
    localparam int DRAW_W    = PROB_BITS;
    localparam int SUM_W     = PROB_W + IDX_W;
    localparam int TRANS_D   = MAX_STATES * MAX_STATES;
    localparam int TRANS_A_W = 2 * IDX_W;

    localparam int S_TDATA_W = ((2 * IDX_W + PROB_W + DRAW_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IDX_W + 7) / 8) * 8;
    localparam int MODE_W    = 2;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CNT_W-1:0] STATES_RESET = CNT_W'(2);

    // register indexes (paddr / 4)
    localparam logic REG_STATES_IN_USE = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_PRIOR = 2'd0,
        MODE_LOAD_TRANS = 2'd1,
        MODE_DRAW_FIRST = 2'd2,
        MODE_DRAW_NEXT  = 2'd3
    } mode_t;

    typedef struct packed {
        logic load;     // write one table entry from the accepted request
        logic capture;  // latch a draw request and clear the running sum
        logic issue;    // present the next row address to the tables
        logic walk;     // accumulate the entry that just came back
        logic emit;     // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic finish;   // current entry ended the walk
    } status_t;

endpackage

[rtl/msps_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module msps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/msps_ctrl.sv]
`timescale 1ns / 1ps
// controller state machine for request acceptance, row walk and result hand-off
module msps_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [msps_pkg::MODE_W-1:0]   s_mode,
    output logic                          s_tready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  msps_pkg::status_t             status,
    output msps_pkg::cmd_t                cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (msps_pkg::mode_t'(s_mode))
                        msps_pkg::MODE_LOAD_PRIOR,
                        msps_pkg::MODE_LOAD_TRANS: begin
                            cmd.load = 1'b1;
                        end
                        msps_pkg::MODE_DRAW_FIRST,
                        msps_pkg::MODE_DRAW_NEXT: begin
                            cmd.capture = 1'b1;
                            state_next  = ST_PRIME;
                        end
                    endcase
                end
            end
            ST_PRIME: begin
                cmd.issue  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                cmd.issue = 1'b1;
                cmd.walk  = 1'b1;
                if (status.finish) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_finish_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        status.finish |-> state_reg == ST_WALK)
        else $error("walk finish outside walk state");

    a_capture_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == ST_PRIME && !s_tready)
        else $error("draw request did not start a walk");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("emitted result not presented");
`endif

endmodule

[rtl/msps_dp.sv]
`timescale 1ns / 1ps
// datapath: probability tables, running sum, compare and result registers
module msps_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msps_pkg::cmd_t                cmd,
    output msps_pkg::status_t             status,
    input  logic [msps_pkg::MODE_W-1:0]   s_mode,
    input  logic [msps_pkg::IDX_W-1:0]    s_row_index,
    input  logic [msps_pkg::IDX_W-1:0]    s_column_index,
    input  logic [msps_pkg::PROB_W-1:0]   s_probability,
    input  logic [msps_pkg::DRAW_W-1:0]   s_random_draw,
    input  logic [msps_pkg::CNT_W-1:0]    states_in_use,
    output logic [msps_pkg::IDX_W-1:0]    m_drawn_state,
    output logic                          m_past_total
);

    logic [msps_pkg::IDX_W-1:0]  last_state_reg;
    logic [msps_pkg::IDX_W-1:0]  src_row_reg;
    logic                        first_reg;
    logic [msps_pkg::DRAW_W-1:0] draw_reg;
    logic [msps_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [msps_pkg::IDX_W-1:0]  issue_idx_reg;
    logic [msps_pkg::IDX_W-1:0]  eval_idx_reg;
    logic [msps_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [msps_pkg::IDX_W-1:0]  res_state_reg;
    logic                        res_over_reg;
    logic [msps_pkg::IDX_W-1:0]  out_state_reg;
    logic                        out_over_reg;

    logic                          prior_we, trans_we;
    logic [msps_pkg::PROB_W-1:0]   prior_rd, trans_rd, entry;
    logic [msps_pkg::TRANS_A_W-1:0] trans_wr_addr, trans_rd_addr;
    logic                          hit, last_entry;

    assign prior_we = cmd.load && (msps_pkg::mode_t'(s_mode) == msps_pkg::MODE_LOAD_PRIOR);
    assign trans_we = cmd.load && (msps_pkg::mode_t'(s_mode) == msps_pkg::MODE_LOAD_TRANS);
    assign trans_wr_addr = {s_row_index, s_column_index};
    assign trans_rd_addr = {src_row_reg, issue_idx_reg};

    msps_ram #(
        .WIDTH(msps_pkg::PROB_W),
        .DEPTH(msps_pkg::MAX_STATES)
    ) u_prior_ram (
        .aclk    (aclk),
        .wr_en   (prior_we),
        .wr_addr (s_column_index),
        .wr_data (s_probability),
        .rd_addr (issue_idx_reg),
        .rd_data (prior_rd)
    );

    msps_ram #(
        .WIDTH(msps_pkg::PROB_W),
        .DEPTH(msps_pkg::TRANS_D)
    ) u_trans_ram (
        .aclk    (aclk),
        .wr_en   (trans_we),
        .wr_addr (trans_wr_addr),
        .wr_data (s_probability),
        .rd_addr (trans_rd_addr),
        .rd_data (trans_rd)
    );

    // zero acts as one state, anything above the table size as the full table
    always_comb begin
        priority if (states_in_use == '0) begin
            n_next = msps_pkg::CNT_W'(1);
        end else if (states_in_use > msps_pkg::CNT_W'(msps_pkg::MAX_STATES)) begin
            n_next = msps_pkg::CNT_W'(msps_pkg::MAX_STATES);
        end else begin
            n_next = states_in_use;
        end
    end

    assign entry      = first_reg ? prior_rd : trans_rd;
    assign sum_next   = sum_reg + msps_pkg::SUM_W'(entry);
    assign hit        = sum_next > msps_pkg::SUM_W'(draw_reg);
    assign last_entry = {1'b0, eval_idx_reg} == (n_reg - msps_pkg::CNT_W'(1));

    assign status.finish = cmd.walk && (hit || last_entry);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_state_reg <= '0;
            issue_idx_reg  <= '0;
            eval_idx_reg   <= '0;
        end else begin
            if (cmd.capture) begin
                issue_idx_reg <= '0;
                eval_idx_reg  <= '0;
            end else begin
                if (cmd.issue) begin
                    issue_idx_reg <= issue_idx_reg + msps_pkg::IDX_W'(1);
                end
                if (cmd.walk) begin
                    eval_idx_reg <= eval_idx_reg + msps_pkg::IDX_W'(1);
                end
            end
            if (cmd.emit) begin
                last_state_reg <= res_state_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            first_reg   <= (msps_pkg::mode_t'(s_mode) == msps_pkg::MODE_DRAW_FIRST);
            src_row_reg <= last_state_reg;
            draw_reg    <= s_random_draw;
            n_reg       <= n_next;
            sum_reg     <= '0;
        end else if (cmd.walk) begin
            sum_reg <= sum_next;
        end
        // the chosen index is the current entry whether it hit or ran off the row
        if (status.finish) begin
            res_state_reg <= eval_idx_reg;
            res_over_reg  <= !hit;
        end
        if (cmd.emit) begin
            out_state_reg <= res_state_reg;
            out_over_reg  <= res_over_reg;
        end
    end

    assign m_drawn_state = out_state_reg;
    assign m_past_total  = out_over_reg;

`ifndef NO_ASSERTIONS
    a_walk_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> {1'b0, eval_idx_reg} < n_reg)
        else $error("walk ran beyond the states in use");

    a_last_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> last_state_reg == out_state_reg)
        else $error("last state differs from emitted state");

    a_issue_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> issue_idx_reg == eval_idx_reg + msps_pkg::IDX_W'(1))
        else $error("read address not one entry ahead of the sum");
`endif

endmodule

[rtl/markov_state_path_sampler.sv]
`timescale 1ns / 1ps
// top level of the markov state path sampler: apb register, controller and datapath
// load requests produce no result; the next request is taken right after
// draw requests: after acceptance the controller primes the table read, then the walk reads
// one table entry per cycle through the ram read port up to the chosen entry (1..states in use);
// the next draw is taken once the result enters the output register, which waits out receiver stalls
// reset (aresetn low, synchronous) clears control, last state to 0 and states_in_use to 2
module markov_state_path_sampler (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: row_index[3:0], column_index[7:4], probability[24:8], random_draw[40:25]
    input  logic [msps_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: mode[1:0]
    input  logic [msps_pkg::MODE_W-1:0]       s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: drawn_state[3:0]
    output logic [msps_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: past_total[0]
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msps_pkg::PADDR_W-1:0]      paddr,
    input  logic [msps_pkg::PDATA_W-1:0]      pwdata,
    output logic [msps_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int ROW_LO  = 0;
    localparam int COL_LO  = ROW_LO + msps_pkg::IDX_W;
    localparam int PROB_LO = COL_LO + msps_pkg::IDX_W;
    localparam int DRAW_LO = PROB_LO + msps_pkg::PROB_W;

    logic [msps_pkg::CNT_W-1:0] states_reg;
    logic                       reg_sel;
    logic                       wr_req;
    msps_pkg::cmd_t             cmd;
    msps_pkg::status_t          status;
    logic [msps_pkg::IDX_W-1:0] drawn_state;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_req  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            states_reg <= msps_pkg::STATES_RESET;
        end else if (wr_req && reg_sel == msps_pkg::REG_STATES_IN_USE) begin
            states_reg <= pwdata[msps_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel == msps_pkg::REG_STATES_IN_USE) begin
            prdata = msps_pkg::PDATA_W'(states_reg);
        end
    end

    msps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msps_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_mode         (s_tuser),
        .s_row_index    (s_tdata[ROW_LO +: msps_pkg::IDX_W]),
        .s_column_index (s_tdata[COL_LO +: msps_pkg::IDX_W]),
        .s_probability  (s_tdata[PROB_LO +: msps_pkg::PROB_W]),
        .s_random_draw  (s_tdata[DRAW_LO +: msps_pkg::DRAW_W]),
        .states_in_use  (states_reg),
        .m_drawn_state  (drawn_state),
        .m_past_total   (m_tuser)
    );

    assign m_tdata = msps_pkg::M_TDATA_W'(drawn_state);

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the markov state path sampler: directed table, random paths
module tb;
    import msps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASE_REQUESTS = 75;
    localparam int NUM_PHASES     = 9;

    localparam logic [PADDR_W-1:0] STATES_ADDR = PADDR_W'(4 * int'(REG_STATES_IN_USE));

    typedef struct packed {
        mode_t             mode;
        logic [IDX_W-1:0]  row_idx;
        logic [IDX_W-1:0]  col_idx;
        logic [PROB_W-1:0] prob;
        logic [DRAW_W-1:0] draw;
    } sample_req_t;

    typedef struct packed {
        logic [IDX_W-1:0] state;
        logic             over;
    } path_result_t;

    typedef struct packed {
        sample_req_t  rq;
        logic         fixed;
        path_result_t res;
    } directed_row_t;

    localparam path_result_t NO_RES = '0;

    // runs with two states in use (reset value)
    localparam directed_row_t DIRECTED_ROWS [25] = '{
        '{'{MODE_LOAD_TRANS, 4'd0,  4'd0,  17'd65536, 16'd0},     1'b0, NO_RES},
        '{'{MODE_LOAD_TRANS, 4'd0,  4'd1,  17'd0,     16'd0},     1'b0, NO_RES},
        // step before any start walks row 0
        '{'{MODE_DRAW_NEXT,  4'd0,  4'd0,  17'd0,     16'd65535}, 1'b1, '{4'd0, 1'b0}},
        '{'{MODE_LOAD_PRIOR, 4'd15, 4'd0,  17'd0,     16'd0},     1'b0, NO_RES},
        '{'{MODE_LOAD_PRIOR, 4'd15, 4'd1,  17'd65536, 16'd0},     1'b0, NO_RES},
        '{'{MODE_DRAW_FIRST, 4'd0,  4'd0,  17'd0,     16'd0},     1'b1, '{4'd1, 1'b0}},
        '{'{MODE_LOAD_TRANS, 4'd1,  4'd0,  17'd0,     16'd0},     1'b0, NO_RES},
        '{'{MODE_LOAD_TRANS, 4'd1,  4'd1,  17'd0,     16'd0},     1'b0, NO_RES},
        // all-zero row: draw runs past the total and saturates
        '{'{MODE_DRAW_NEXT,  4'd0,  4'd0,  17'd0,     16'd0},     1'b1, '{4'd1, 1'b1}},
        '{'{MODE_DRAW_NEXT,  4'd0,  4'd0,  17'd0,     16'd65535}, 1'b1, '{4'd1, 1'b1}},
        '{'{MODE_LOAD_TRANS, 4'd1,  4'd0,  17'd32768, 16'd0},     1'b0, NO_RES},
        '{'{MODE_LOAD_TRANS, 4'd1,  4'd1,  17'd32768, 16'd0},     1'b0, NO_RES},
        '{'{MODE_DRAW_NEXT,  4'd0,  4'd0,  17'd0,     16'd32767}, 1'b1, '{4'd0, 1'b0}},
        '{'{MODE_DRAW_FIRST, 4'd0,  4'd0,  17'd0,     16'd65535}, 1'b1, '{4'd1, 1'b0}},
        // sum equal to the draw does not select
        '{'{MODE_DRAW_NEXT,  4'd0,  4'd0,  17'd0,     16'd32768}, 1'b1, '{4'd1, 1'b0}},
        '{'{MODE_LOAD_PRIOR, 4'd0,  4'd0,  17'd1,     16'd0},     1'b0, NO_RES},
        '{'{MODE_LOAD_PRIOR, 4'd0,  4'd1,  17'd1,     16'd0},     1'b0, NO_RES},
        '{'{MODE_DRAW_FIRST, 4'd0,  4'd0,  17'd0,     16'd1},     1'b1, '{4'd1, 1'b0}},
        '{'{MODE_DRAW_FIRST, 4'd0,  4'd0,  17'd0,     16'd2},     1'b1, '{4'd1, 1'b1}},
        '{'{MODE_DRAW_FIRST, 4'd0,  4'd0,  17'd0,     16'd0},     1'b1, '{4'd0, 1'b0}},
        // row total above one
        '{'{MODE_LOAD_TRANS, 4'd0,  4'd0,  17'd1,     16'd0},     1'b0, NO_RES},
        '{'{MODE_LOAD_TRANS, 4'd0,  4'd1,  17'd65536, 16'd0},     1'b0, NO_RES},
        '{'{MODE_DRAW_NEXT,  4'd0,  4'd0,  17'd0,     16'd65535}, 1'b1, '{4'd1, 1'b0}},
        '{'{MODE_LOAD_TRANS, 4'd15, 4'd15, 17'd65535, 16'd0},     1'b0, NO_RES},
        '{'{MODE_LOAD_PRIOR, 4'd0,  4'd15, 17'd65536, 16'd0},     1'b0, NO_RES}
    };

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // predictor state
    logic [CNT_W-1:0]  cfg_states;
    logic [PROB_W-1:0] prior_tab [MAX_STATES];
    logic [PROB_W-1:0] trans_tab [MAX_STATES][MAX_STATES];
    bit                prior_set [MAX_STATES];
    bit                trans_set [MAX_STATES][MAX_STATES];
    logic [IDX_W-1:0]  path_state;
    path_result_t      drawn_q [$];

    int errors;
    int n_loads;
    int n_draws;
    int n_checked;
    int n_saturated;
    int n_settings;
    int burst_left;
    int rdy_run;
    int rdy_stall;
    int idle_cycles;

    markov_state_path_sampler i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic int unsigned active_states();
        if (cfg_states == 0) return 1;
        if (cfg_states > MAX_STATES) return MAX_STATES;
        return cfg_states;
    endfunction

    function automatic int unsigned row_entry(input bit from_prior, input int i);
        return from_prior ? prior_tab[i] : trans_tab[path_state][i];
    endfunction

    // a draw may only walk entries that were loaded
    function automatic bit row_written(input bit from_prior);
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < active_states(); i++)
            if (from_prior ? !prior_set[i] : !trans_set[path_state][i]) ok = 1'b0;
        return ok;
    endfunction

    function automatic bit predict_request(input sample_req_t rq, output path_result_t res);
        int unsigned n;
        int unsigned sum;
        bit          found;
        bit          from_prior;
        res = '0;
        case (rq.mode)
            MODE_LOAD_PRIOR: begin
                prior_tab[rq.col_idx] = rq.prob;
                prior_set[rq.col_idx] = 1'b1;
                return 1'b0;
            end
            MODE_LOAD_TRANS: begin
                trans_tab[rq.row_idx][rq.col_idx] = rq.prob;
                trans_set[rq.row_idx][rq.col_idx] = 1'b1;
                return 1'b0;
            end
            default: begin
                n = active_states();
                from_prior = (rq.mode == MODE_DRAW_FIRST);
                sum = 0;
                found = 1'b0;
                res.state = IDX_W'(n - 1);
                res.over = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (!found) begin
                        sum += row_entry(from_prior, i);
                        if (sum > rq.draw) begin
                            found = 1'b1;
                            res.state = IDX_W'(i);
                            res.over = 1'b0;
                        end
                    end
                end
                path_state = res.state;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic sample_req_t random_fields();
        sample_req_t rq;
        rq.mode    = mode_t'($urandom_range(0, 3));
        rq.row_idx = IDX_W'($urandom_range(0, MAX_STATES - 1));
        rq.col_idx = IDX_W'($urandom_range(0, MAX_STATES - 1));
        rq.prob    = PROB_W'($urandom_range(0, 65536));
        rq.draw    = DRAW_W'($urandom_range(0, 65535));
        return rq;
    endfunction

    // mostly uniform, sometimes right at a running-sum boundary
    function automatic logic [DRAW_W-1:0] pick_draw(input bit from_prior);
        int unsigned k;
        int          partial;
        if ($urandom_range(0, 4) != 0) return DRAW_W'($urandom_range(0, 65535));
        k = $urandom_range(0, active_states() - 1);
        partial = 0;
        for (int i = 0; i <= k; i++) partial += row_entry(from_prior, i);
        partial -= $urandom_range(0, 1);
        if (partial < 0) partial = 0;
        if (partial > 65535) partial = 65535;
        return DRAW_W'(partial);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned expected,
                                   input int unsigned got);
        $display("mismatch: %s: expected %0d, got %0d", what, expected, got);
        errors++;
    endtask

    task automatic send_request(input sample_req_t rq, input bit fixed,
                                input path_result_t fixed_res);
        int           gap;
        path_result_t res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.mode;
        s_tdata  <= S_TDATA_W'({rq.draw, rq.prob, rq.col_idx, rq.row_idx});
        do @(posedge aclk); while (!s_tready);
        if (predict_request(rq, res)) begin
            drawn_q.push_back(fixed ? fixed_res : res);
            n_draws++;
        end else begin
            n_loads++;
        end
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic apb_transfer(input bit is_write, input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= STATES_ADDR;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // wait for the last draw, then cover a possible walk still in flight
    task automatic settle();
        while (drawn_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_states(input int unsigned value);
        logic [PDATA_W-1:0] rd;
        s_tvalid <= 1'b0;
        settle();
        apb_transfer(1'b1, PDATA_W'(value), rd);
        cfg_states = CNT_W'(value);
        apb_transfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(cfg_states))
            report_mismatch("states_in_use readback", cfg_states, rd);
        n_settings++;
        burst_left = 0;
    endtask

    // load one row as a distribution over the states in use
    task automatic load_row(input bit to_prior, input logic [IDX_W-1:0] src);
        int unsigned n;
        int unsigned pick;
        int unsigned total;
        int unsigned wsum;
        int unsigned acc;
        int unsigned v;
        int unsigned w [MAX_STATES];
        sample_req_t rq;
        n = active_states();
        pick = $urandom_range(0, 9);
        if (pick < 6) total = 65536;
        else if (pick < 8) total = $urandom_range(0, 65535);
        else total = $urandom_range(60000, 65536);
        wsum = 0;
        for (int i = 0; i < n; i++) begin
            w[i] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
            wsum += w[i];
        end
        if (wsum == 0) begin
            w[n - 1] = 1;
            wsum = 1;
        end
        acc = 0;
        for (int i = 0; i < n; i++) begin
            v = (i == n - 1) ? total - acc : total * w[i] / wsum;
            acc += v;
            rq = random_fields();
            rq.mode = to_prior ? MODE_LOAD_PRIOR : MODE_LOAD_TRANS;
            if (!to_prior) rq.row_idx = src;
            rq.col_idx = IDX_W'(i);
            rq.prob = PROB_W'(v);
            send_request(rq, 1'b0, NO_RES);
        end
    endtask

    task automatic run_random(input int count);
        int          sent;
        int          pick;
        int unsigned n;
        bit          first;
        sample_req_t rq;
        sent = 0;
        while (sent < count) begin
            n = active_states();
            pick = $urandom_range(0, 99);
            rq = random_fields();
            if (pick < 8) begin
                // stray table write anywhere
                rq.mode = ($urandom_range(0, 1) != 0) ? MODE_LOAD_PRIOR : MODE_LOAD_TRANS;
                send_request(rq, 1'b0, NO_RES);
                sent++;
            end else if (pick < 16) begin
                load_row(1'b1, '0);
                sent += n;
            end else if (pick < 26) begin
                load_row(1'b0, IDX_W'($urandom_range(0, MAX_STATES - 1)));
                sent += n;
            end else begin
                first = ($urandom_range(0, 9) < 3);
                if (!row_written(first)) begin
                    load_row(first, path_state);
                    sent += n;
                end
                rq.mode = first ? MODE_DRAW_FIRST : MODE_DRAW_NEXT;
                rq.draw = pick_draw(first);
                send_request(rq, 1'b0, NO_RES);
                sent++;
            end
        end
    endtask

    // receiver: ready runs broken by stalls of random length
    always @(negedge aclk) begin
        if (rdy_run > 0) begin
            m_tready <= 1'b1;
            rdy_run  <= rdy_run - 1;
        end else if (rdy_stall > 0) begin
            m_tready  <= 1'b0;
            rdy_stall <= rdy_stall - 1;
        end else begin
            m_tready  <= 1'b1;
            rdy_run   <= $urandom_range(0, 24);
            rdy_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
        end
    end

    always @(posedge aclk) begin : result_check
        path_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (drawn_q.size() == 0) begin
                report_mismatch("result with no draw pending, drawn state", 0,
                                m_tdata[IDX_W-1:0]);
            end else begin
                want = drawn_q.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.state)
                    report_mismatch("drawn_state", want.state, m_tdata[IDX_W-1:0]);
                if (m_tuser !== want.over)
                    report_mismatch("past_total", want.over, m_tuser);
                n_checked++;
                if (want.over) n_saturated++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d draws pending",
                     idle_cycles, drawn_q.size());
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [PDATA_W-1:0] rd;
        int unsigned        phase_setting [NUM_PHASES];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cfg_states  = STATES_RESET;
        path_state  = '0;
        errors      = 0;
        n_loads     = 0;
        n_draws     = 0;
        n_checked   = 0;
        n_saturated = 0;
        n_settings  = 0;
        burst_left  = 0;
        // extremes, out-of-range values and one random count
        phase_setting = '{16, 1, 0, 5, 31, 17, 3, 16, 2};
        phase_setting[7] = $urandom_range(1, MAX_STATES);

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apb_transfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(STATES_RESET))
            report_mismatch("states_in_use after reset", STATES_RESET, rd);

        foreach (DIRECTED_ROWS[i])
            send_request(DIRECTED_ROWS[i].rq, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].res);

        foreach (phase_setting[p]) begin
            set_states(phase_setting[p]);
            run_random(PHASE_REQUESTS);
        end

        s_tvalid <= 1'b0;
        settle();

        $display("sent %0d requests: %0d table loads and %0d draws across %0d state counts",
                 n_loads + n_draws, n_loads, n_draws, n_settings + 1);
        $display("checked %0d drawn states, %0d saturated past the row total",
                 n_checked, n_saturated);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
